// ===== rtl/spot_pkg.sv =====
// Shared shape codes, pair classes and default widths for the shape pair overlap test.
package spot_pkg;

  localparam int unsigned CoordWidthDef  = 24;
  localparam int unsigned ExtentWidthDef = 16;

  typedef enum logic [1:0] {
    SHAPE_BOX      = 2'd0,
    SHAPE_SPHERE   = 2'd1,
    SHAPE_CYLINDER = 2'd2
  } shape_e;

  typedef enum logic [1:0] {
    CLS_EXTENT      = 2'd0,
    CLS_SPHERES     = 2'd1,
    CLS_SPHERE_BOX  = 2'd2,
    CLS_UNSUPPORTED = 2'd3
  } class_e;

endpackage

// ===== rtl/shape_pair_overlap_test.sv =====
// Shape pair overlap test: a five stage pipeline that gives one hit flag per object pair.
//
// One beat on the slave stream carries one pair of objects: the center offset
// (first minus second), the half extents of both objects and both shape codes.
// One beat on the master stream returns the hit flag and the pair class.
// Boxes and cylinders of the same kind use a per-axis extent test, two spheres
// compare squared distance with the squared radius sum, and a sphere with a box
// clamps the offset to the box first. Any other pair gives class three, no hit.
//
// A new pair is taken every cycle unless a receiver stall has filled the
// pipeline; the five register stages (magnitude, clamp, square, sum, compare)
// each hold one pair, and the squaring stage sets the clock.
// Valid bits travel with the data, and each stage is ready when it is empty or
// the stage after it moves, so bubbles close up while the receiver stalls.
// When the receiver holds tready low, results stay in place and the block keeps
// taking pairs until every stage is full. Reset empties the pipeline only.
module shape_pair_overlap_test
  import spot_pkg::*;
#(
  parameter int unsigned COORD_WIDTH  = CoordWidthDef,
  parameter int unsigned EXTENT_WIDTH = ExtentWidthDef,
  localparam int unsigned InW = ((3 * COORD_WIDTH + 6 * EXTENT_WIDTH + 7) / 8) * 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_axis_tvalid_i,
  output logic           s_axis_tready_o,
  // offset_x, offset_y, offset_z, first_extent_x/y/z, second_extent_x/y/z, zero fill
  input  logic [InW-1:0] s_axis_tdata_i,
  // first_shape, second_shape
  input  logic [3:0]     s_axis_tuser_i,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  // hit, zero fill
  output logic [7:0]     m_axis_tdata_o,
  // pair_class
  output logic [1:0]     m_axis_tuser_o
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned EW    = EXTENT_WIDTH;
  localparam int unsigned RW    = EW + 1;
  localparam int unsigned XW    = (CW > RW) ? CW : RW;
  localparam int unsigned SqW   = 2 * CW;
  localparam int unsigned SumW  = SqW + 2;
  localparam int unsigned RsqW  = 2 * RW;
  localparam int unsigned CmpW  = (SumW > RsqW) ? SumW : RsqW;
  localparam int unsigned NStg  = 5;

  // Stage handshake.
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] go;

  always_comb begin
    go[NStg-1] = !v_q[NStg-1] || m_axis_tready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      go[k] = !v_q[k] || go[k+1];
    end
  end

  assign s_axis_tready_o = go[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (go[0]) begin
        v_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (go[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Stage 1: magnitudes, extent sums, operand selection and pair class.
  logic signed [CW-1:0] off [3];
  logic [EW-1:0]        e1 [3];
  logic [EW-1:0]        e2 [3];
  shape_e               shp1, shp2;

  logic [CW-1:0] mag1_d [3];
  logic [RW-1:0] esum1_d [3];
  logic [EW-1:0] box1_d [3];
  logic [RW-1:0] rad1_d;
  class_e        cls1_d;

  logic [CW-1:0] mag1_q [3];
  logic [RW-1:0] esum1_q [3];
  logic [EW-1:0] box1_q [3];
  logic [RW-1:0] rad1_q;
  class_e        cls1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = s_axis_tdata_i[i*CW +: CW];
      e1[i]  = s_axis_tdata_i[3*CW + i*EW +: EW];
      e2[i]  = s_axis_tdata_i[3*CW + (3+i)*EW +: EW];
    end
    shp1 = shape_e'(s_axis_tuser_i[1:0]);
    shp2 = shape_e'(s_axis_tuser_i[3:2]);

    for (int i = 0; i < 3; i++) begin
      // The most negative offset has magnitude 2^(CW-1), which still fits unsigned.
      mag1_d[i]  = off[i][CW-1] ? (~off[i] + CW'(1)) : off[i];
      esum1_d[i] = RW'(e1[i]) + RW'(e2[i]);
      box1_d[i]  = (shp1 == SHAPE_BOX) ? e1[i] : e2[i];
    end

    if ((shp1 == SHAPE_BOX && shp2 == SHAPE_BOX) ||
        (shp1 == SHAPE_CYLINDER && shp2 == SHAPE_CYLINDER)) begin
      cls1_d = CLS_EXTENT;
    end else if (shp1 == SHAPE_SPHERE && shp2 == SHAPE_SPHERE) begin
      cls1_d = CLS_SPHERES;
    end else if ((shp1 == SHAPE_SPHERE && shp2 == SHAPE_BOX) ||
                 (shp1 == SHAPE_BOX && shp2 == SHAPE_SPHERE)) begin
      cls1_d = CLS_SPHERE_BOX;
    end else begin
      cls1_d = CLS_UNSUPPORTED;
    end

    if (cls1_d == CLS_SPHERES) begin
      rad1_d = esum1_d[0];
    end else if (shp1 == SHAPE_SPHERE) begin
      rad1_d = RW'(e1[0]);
    end else begin
      rad1_d = RW'(e2[0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[0]) begin
      mag1_q  <= mag1_d;
      esum1_q <= esum1_d;
      box1_q  <= box1_d;
      rad1_q  <= rad1_d;
      cls1_q  <= cls1_d;
    end
  end

  // Stage 2: per-axis extent test and clamp of the offset to the box.
  logic [CW-1:0] op2_d [3];
  logic          ext2_d;
  logic [XW-1:0] magx, boxx, diffx;

  logic [CW-1:0] op2_q [3];
  logic          ext2_q;
  logic [RW-1:0] rad2_q;
  class_e        cls2_q;

  always_comb begin
    ext2_d = 1'b1;
    magx   = '0;
    boxx   = '0;
    diffx  = '0;
    for (int i = 0; i < 3; i++) begin
      magx = XW'(mag1_q[i]);
      if (magx > XW'(esum1_q[i])) begin
        ext2_d = 1'b0;
      end
      boxx  = XW'(box1_q[i]);
      diffx = (magx > boxx) ? (magx - boxx) : '0;
      // Sphere pairs square the magnitude itself, sphere-box pairs the excess.
      op2_d[i] = (cls1_q == CLS_SPHERES) ? mag1_q[i] : diffx[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (go[1]) begin
      op2_q  <= op2_d;
      ext2_q <= ext2_d;
      rad2_q <= rad1_q;
      cls2_q <= cls1_q;
    end
  end

  // Stage 3: squares.
  logic [SqW-1:0]  sq3_q [3];
  logic [RsqW-1:0] rsq3_q;
  logic            ext3_q;
  class_e          cls3_q;

  always_ff @(posedge clk_i) begin
    if (go[2]) begin
      for (int i = 0; i < 3; i++) begin
        sq3_q[i] <= SqW'(op2_q[i]) * SqW'(op2_q[i]);
      end
      rsq3_q <= RsqW'(rad2_q) * RsqW'(rad2_q);
      ext3_q <= ext2_q;
      cls3_q <= cls2_q;
    end
  end

  // Stage 4: squared distance.
  logic [SumW-1:0] d2_q;
  logic [RsqW-1:0] rsq4_q;
  logic            ext4_q;
  class_e          cls4_q;

  always_ff @(posedge clk_i) begin
    if (go[3]) begin
      d2_q   <= SumW'(sq3_q[0]) + SumW'(sq3_q[1]) + SumW'(sq3_q[2]);
      rsq4_q <= rsq3_q;
      ext4_q <= ext3_q;
      cls4_q <= cls3_q;
    end
  end

  // Stage 5: final compare into the output register.
  logic   hit5_d;
  logic   hit5_q;
  class_e cls5_q;

  always_comb begin
    case (cls4_q) inside
      CLS_EXTENT:                  hit5_d = ext4_q;
      CLS_SPHERES, CLS_SPHERE_BOX: hit5_d = (CmpW'(d2_q) <= CmpW'(rsq4_q));
      default:                     hit5_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (go[4]) begin
      hit5_q <= hit5_d;
      cls5_q <= cls4_q;
    end
  end

  assign m_axis_tvalid_o = v_q[NStg-1];
  assign m_axis_tdata_o  = {7'd0, hit5_q};
  assign m_axis_tuser_o  = cls5_q;

`ifndef SYNTHESIS
  a_unsup_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == CLS_UNSUPPORTED) |-> !m_axis_tdata_o[0])
    else $error("unsupported pair reported a hit");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> v_q[0])
    else $error("accepted beat did not enter the first stage");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[3] && !go[3]) |=> (v_q[3] && $stable(d2_q)))
    else $error("stalled stage lost or changed its pair");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the shape pair overlap test block.
`timescale 1ns / 1ps

module tb_top
  import spot_pkg::*;
();

  localparam int CW = CoordWidthDef;
  localparam int EW = ExtentWidthDef;
  localparam int InW = ((3 * CW + 6 * EW + 7) / 8) * 8;
  localparam int HoldCycles = 60;
  localparam logic [1:0] ShapeCodeThree = 2'd3;

  typedef struct packed {
    logic [2:0][CW-1:0] offset;
    logic [2:0][EW-1:0] first_ext;
    logic [2:0][EW-1:0] second_ext;
    logic [1:0]         first_shape;
    logic [1:0]         second_shape;
  } pair_t;

  typedef struct packed {
    logic   hit;
    class_e cls;
  } overlap_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           s_tvalid = 1'b0;
  logic           s_tready;
  // offset_x, offset_y, offset_z, first_extent_x/y/z, second_extent_x/y/z, zero fill
  logic [InW-1:0] s_tdata = '0;
  // first_shape, second_shape
  logic [3:0]     s_tuser = '0;
  logic           m_tvalid;
  logic           m_tready = 1'b0;
  // hit, zero fill
  logic [7:0]     m_tdata;
  // pair_class
  logic [1:0]     m_tuser;

  overlap_t pending_overlaps[$];
  int       errors = 0;
  logic     steady_flow = 1'b0;
  int       hold_requests = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  shape_pair_overlap_test u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic overlap_t predict_overlap(input pair_t p);
    overlap_t        r;
    longint unsigned mag [3];
    longint unsigned box;
    longint unsigned over;
    longint unsigned radius;
    longint unsigned rsum;
    longint unsigned d2;
    logic [1:0]      s1;
    logic [1:0]      s2;
    s1 = p.first_shape;
    s2 = p.second_shape;
    r.hit = 1'b0;
    r.cls = CLS_UNSUPPORTED;
    d2 = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = p.offset[i][CW-1] ? (64'd1 << CW) - 64'(p.offset[i]) : 64'(p.offset[i]);
    end
    if ((s1 == SHAPE_BOX && s2 == SHAPE_BOX) ||
        (s1 == SHAPE_CYLINDER && s2 == SHAPE_CYLINDER)) begin
      r.cls = CLS_EXTENT;
      r.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
        if (mag[i] > 64'(p.first_ext[i]) + 64'(p.second_ext[i])) r.hit = 1'b0;
      end
    end else if (s1 == SHAPE_SPHERE && s2 == SHAPE_SPHERE) begin
      r.cls = CLS_SPHERES;
      rsum = 64'(p.first_ext[0]) + 64'(p.second_ext[0]);
      for (int i = 0; i < 3; i++) d2 += mag[i] * mag[i];
      r.hit = (d2 <= rsum * rsum);
    end else if ((s1 == SHAPE_SPHERE && s2 == SHAPE_BOX) ||
                 (s1 == SHAPE_BOX && s2 == SHAPE_SPHERE)) begin
      r.cls = CLS_SPHERE_BOX;
      radius = (s1 == SHAPE_SPHERE) ? 64'(p.first_ext[0]) : 64'(p.second_ext[0]);
      for (int i = 0; i < 3; i++) begin
        box = (s1 == SHAPE_BOX) ? 64'(p.first_ext[i]) : 64'(p.second_ext[i]);
        over = (mag[i] > box) ? mag[i] - box : 0;
        d2 += over * over;
      end
      r.hit = (d2 <= radius * radius);
    end
    return r;
  endfunction

  function automatic pair_t pair_of(input logic [1:0] s1, input logic [1:0] s2,
                                    input int ox, input int oy, input int oz,
                                    input int e1x, input int e1y, input int e1z,
                                    input int e2x, input int e2y, input int e2z);
    pair_t p;
    p.first_shape = s1;
    p.second_shape = s2;
    p.offset[0] = CW'(ox);
    p.offset[1] = CW'(oy);
    p.offset[2] = CW'(oz);
    p.first_ext[0] = EW'(e1x);
    p.first_ext[1] = EW'(e1y);
    p.first_ext[2] = EW'(e1z);
    p.second_ext[0] = EW'(e2x);
    p.second_ext[1] = EW'(e2y);
    p.second_ext[2] = EW'(e2z);
    return p;
  endfunction

  function automatic pair_t random_pair();
    pair_t       p;
    int unsigned pick;
    int unsigned span;
    int unsigned dist_mag;
    pick = $urandom_range(99);
    if (pick < 10) begin
      p.first_shape = 2'($urandom_range(3));
      p.second_shape = 2'($urandom_range(3));
    end else if (pick < 35) begin
      p.first_shape = 2'($urandom_range(2));
      p.second_shape = 2'($urandom_range(2));
    end else begin
      case ($urandom_range(4))
        0: begin
          p.first_shape = SHAPE_BOX;
          p.second_shape = SHAPE_BOX;
        end
        1: begin
          p.first_shape = SHAPE_CYLINDER;
          p.second_shape = SHAPE_CYLINDER;
        end
        2: begin
          p.first_shape = SHAPE_SPHERE;
          p.second_shape = SHAPE_SPHERE;
        end
        3: begin
          p.first_shape = SHAPE_SPHERE;
          p.second_shape = SHAPE_BOX;
        end
        default: begin
          p.first_shape = SHAPE_BOX;
          p.second_shape = SHAPE_SPHERE;
        end
      endcase
    end
    pick = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (pick < 60) begin
        p.first_ext[i] = EW'($urandom_range(1023));
        p.second_ext[i] = EW'($urandom_range(1023));
      end else if (pick < 85) begin
        p.first_ext[i] = EW'($urandom);
        p.second_ext[i] = EW'($urandom);
      end else begin
        p.first_ext[i] = $urandom_range(1) ? {EW{1'b1}} : '0;
        p.second_ext[i] = $urandom_range(1) ? {EW{1'b1}} : '0;
      end
    end
    // Most offsets land near the summed extents so that both hits and misses occur.
    for (int i = 0; i < 3; i++) begin
      pick = $urandom_range(99);
      if (pick < 15) begin
        p.offset[i] = CW'($urandom);
      end else if (pick < 25) begin
        case ($urandom_range(3))
          0: p.offset[i] = '0;
          1: p.offset[i] = '1;
          2: p.offset[i] = {1'b1, {(CW-1){1'b0}}};
          default: p.offset[i] = {1'b0, {(CW-1){1'b1}}};
        endcase
      end else begin
        span = p.first_ext[i] + p.second_ext[i] + 64;
        dist_mag = $urandom_range(span);
        p.offset[i] = $urandom_range(1) ? CW'(-dist_mag) : CW'(dist_mag);
      end
    end
    return p;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid stays high so that the next pair can follow without a gap.
  task automatic send_pair(input pair_t p);
    if (!steady_flow && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    s_tdata <= InW'({p.second_ext, p.first_ext, p.offset});
    s_tuser <= {p.second_shape, p.first_shape};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    pending_overlaps = {pending_overlaps, predict_overlap(p)};
    @(negedge clk_i);
  endtask

  task automatic sender_idle();
    s_tvalid <= 1'b0;
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (steady_flow) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    overlap_t want;
    if (m_tvalid && m_tready) begin
      if (pending_overlaps.size() == 0) begin
        $error("result beat with no pair outstanding");
        errors++;
      end else begin
        want = pending_overlaps.pop_front();
        if (m_tdata[0] !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, m_tdata[0]);
          errors++;
        end
        if (m_tdata[7:1] !== '0) begin
          $error("tdata fill: expected 0, got %0h", m_tdata[7:1]);
          errors++;
        end
        if (m_tuser !== want.cls) begin
          $error("pair_class: expected %0d, got %0d", want.cls, m_tuser);
          errors++;
        end
      end
    end
  end

  task automatic test_directed_cases();
    // Boxes touching on one axis hit; one step further misses.
    send_pair(pair_of(SHAPE_BOX, SHAPE_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(SHAPE_BOX, SHAPE_BOX, 300, 0, 0, 100, 5, 5, 200, 5, 5));
    send_pair(pair_of(SHAPE_BOX, SHAPE_BOX, 301, 0, 0, 100, 5, 5, 200, 5, 5));
    send_pair(pair_of(SHAPE_BOX, SHAPE_BOX, 0, 0, -300, 5, 5, 100, 5, 5, 200));
    send_pair(pair_of(SHAPE_BOX, SHAPE_BOX, 0, 0, -301, 5, 5, 100, 5, 5, 200));
    send_pair(pair_of(SHAPE_CYLINDER, SHAPE_CYLINDER, 0, 1000, 0, 9, 400, 9, 9, 600, 9));
    send_pair(pair_of(SHAPE_CYLINDER, SHAPE_CYLINDER, -8388608, -8388608, -8388608,
                      65535, 65535, 65535, 65535, 65535, 65535));
    send_pair(pair_of(SHAPE_BOX, SHAPE_BOX, 8388607, 8388607, 8388607,
                      65535, 65535, 65535, 65535, 65535, 65535));
    // Spheres: 420-560-700 triangle touches exactly.
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_SPHERE, 420, 560, 0, 300, 0, 0, 400, 0, 0));
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_SPHERE, 421, -560, 0, 300, 0, 0, 400, 0, 0));
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_SPHERE, -8388608, -8388608, -8388608,
                      65535, 65535, 65535, 65535, 65535, 65535));
    // Sphere against box, in both orders.
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_BOX, 400, 400, 100, 500, 0, 0, 100, 100, 100));
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_BOX, 500, 500, 100, 500, 0, 0, 100, 100, 100));
    send_pair(pair_of(SHAPE_BOX, SHAPE_SPHERE, -400, -400, -100, 100, 100, 100, 500, 0, 0));
    send_pair(pair_of(SHAPE_BOX, SHAPE_SPHERE, 150, 0, 0, 100, 0, 0, 50, 0, 0));
    send_pair(pair_of(SHAPE_BOX, SHAPE_SPHERE, 151, 0, 0, 100, 0, 0, 50, 0, 0));
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_BOX, 0, 0, 0, 65535, 65535, 65535,
                      65535, 65535, 65535));
    // Unsupported pairs, including the invalid shape code.
    send_pair(pair_of(SHAPE_BOX, SHAPE_CYLINDER, 0, 0, 0, 10, 10, 10, 10, 10, 10));
    send_pair(pair_of(SHAPE_CYLINDER, SHAPE_BOX, 0, 0, 0, 10, 10, 10, 10, 10, 10));
    send_pair(pair_of(SHAPE_SPHERE, SHAPE_CYLINDER, 0, 0, 0, 10, 10, 10, 10, 10, 10));
    send_pair(pair_of(SHAPE_CYLINDER, SHAPE_SPHERE, 0, 0, 0, 10, 10, 10, 10, 10, 10));
    send_pair(pair_of(ShapeCodeThree, SHAPE_BOX, 0, 0, 0, 10, 10, 10, 10, 10, 10));
    send_pair(pair_of(SHAPE_SPHERE, ShapeCodeThree, 0, 0, 0, 10, 10, 10, 10, 10, 10));
    send_pair(pair_of(ShapeCodeThree, ShapeCodeThree, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    sender_idle();
  endtask

  task automatic test_random_pairs(input int count);
    for (int n = 0; n < count; n++) begin
      // One long stretch runs with both sides always ready.
      steady_flow = (n >= count / 3 && n < count / 3 + 300);
      send_pair(random_pair());
    end
    steady_flow = 1'b0;
    sender_idle();
  endtask

  task automatic test_backpressure_fill();
    @(posedge clk_i);
    hold_requests++;
    @(negedge clk_i);
    for (int n = 0; n < 30; n++) send_pair(random_pair());
    sender_idle();
  endtask

  task automatic test_drain_pause();
    while (pending_overlaps.size() != 0) @(negedge clk_i);
    for (int n = 0; n < 50; n++) send_pair(random_pair());
    sender_idle();
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_random_pairs(1550);
    test_backpressure_fill();
    test_drain_pause();
    while (pending_overlaps.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
